// ===== design/pts_pkg.sv =====
`timescale 1ns / 1ps
package pts_pkg;
  localparam int SLOT_COUNT_DEF = 16;
  localparam int SLOT_W = 5;
  localparam logic [SLOT_W-1:0] NO_SLOT = 5'd31;

  localparam logic [1:0] ST_FREE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_ZOMBIE = 2'd3;

  localparam logic [2:0] KIND_ALLOC = 3'd0;
  localparam logic [2:0] KIND_WAIT  = 3'd1;
  localparam logic [2:0] KIND_RUN   = 3'd2;
  localparam logic [2:0] KIND_TICK  = 3'd3;
  localparam logic [2:0] KIND_EXIT  = 3'd4;

  localparam logic [1:0] REAP_NONE    = 2'd0;
  localparam logic [1:0] REAP_DONE    = 2'd1;
  localparam logic [1:0] REAP_PENDING = 2'd2;

  localparam logic [1:0] WAKE_PLAIN = 2'd0;
  localparam logic [1:0] WAKE_EMPTY = 2'd1;
  localparam logic [1:0] WAKE_REAP  = 2'd2;

  typedef struct packed {
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              zomb_found;
    logic [SLOT_W-1:0] zomb_idx;
    logic [1:0]        reap_code;
    logic [SLOT_W-1:0] child_idx;
  } scan_t;
endpackage

// ===== design/pts_ram.sv =====
`timescale 1ns / 1ps
module pts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/pts_scan.sv =====
`timescale 1ns / 1ps
module pts_scan #(
  parameter int SLOT_COUNT = pts_pkg::SLOT_COUNT_DEF,
  localparam int IW = $clog2(SLOT_COUNT)
) (
  input  logic [1:0]                st [SLOT_COUNT],
  input  logic [pts_pkg::SLOT_W-1:0] par [SLOT_COUNT],
  input  logic [IW-1:0]             p,
  output pts_pkg::scan_t            res,
  output logic [SLOT_COUNT-1:0]     orphan
);
  localparam int SW = pts_pkg::SLOT_W;

  logic has_child;

  // priority by walking downwards so the lowest index wins
  always_comb begin
    res = '0;
    has_child = 1'b0;
    orphan = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (st[i] == pts_pkg::ST_FREE) begin
        res.free_found = 1'b1;
        res.free_idx = SW'(i);
      end
      if (st[i] == pts_pkg::ST_ZOMBIE) begin
        res.zomb_found = 1'b1;
        res.zomb_idx = SW'(i);
      end
      if (par[i] == SW'(p)) begin
        if (st[i] != pts_pkg::ST_FREE) begin
          orphan[i] = 1'b1;
        end
        if (st[i] == pts_pkg::ST_RUN || st[i] == pts_pkg::ST_ZOMBIE) begin
          has_child = 1'b1;
        end
        if (st[i] == pts_pkg::ST_ZOMBIE) begin
          res.child_idx = SW'(i);
        end
      end
    end
    if (orphan != '0 && has_child && res.child_idx != '0 ||
        (has_child && st[res.child_idx[IW-1:0]] == pts_pkg::ST_ZOMBIE &&
         par[res.child_idx[IW-1:0]] == SW'(p))) begin
      res.reap_code = pts_pkg::REAP_DONE;
    end else if (has_child) begin
      res.reap_code = pts_pkg::REAP_PENDING;
    end else begin
      res.reap_code = pts_pkg::REAP_NONE;
    end
    if (res.reap_code == pts_pkg::REAP_DONE &&
        !(st[res.child_idx[IW-1:0]] == pts_pkg::ST_ZOMBIE &&
          par[res.child_idx[IW-1:0]] == SW'(p))) begin
      res.reap_code = pts_pkg::REAP_PENDING;
    end
  end
endmodule

// ===== design/process_table_scheduler.sv =====
`timescale 1ns / 1ps
// flow: idle, exec, then fin; a reaping wait reads the child status (rdst) before fin
// tick: steps one slot at a time from the current slot, up to 2 * SLOT_COUNT slots,
//   then reads the child status from the status ram when a waiter reaps a child
// throughput: one word at a time; the next word is taken once the result has
//   moved into the output register
// reset: synchronous active-low rst_n, all slots free and no current slot
module process_table_scheduler #(
  parameter int SLOT_COUNT = pts_pkg::SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [3:0]  in_target_id,
  input  logic [3:0]  in_parent_id,
  input  logic        in_parent_none,
  input  logic [31:0] in_exit_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_success,
  output logic [3:0]  out_slot_id,
  output logic [3:0]  out_child_id,
  output logic [1:0]  out_wake_code,
  output logic [31:0] out_exit_status
);
  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(2 * SLOT_COUNT);
  localparam int SW = pts_pkg::SLOT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_TICK = 3'd2;
  localparam logic [2:0] S_RDST = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // control
  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [SW-1:0] current_r, current_nxt;
  logic          from_tick_r, from_tick_nxt;

  // slot table state and parent links
  logic [1:0]    st_r [SLOT_COUNT];
  logic [1:0]    st_nxt [SLOT_COUNT];
  logic [SW-1:0] par_r [SLOT_COUNT];
  logic [SW-1:0] par_nxt [SLOT_COUNT];

  // latched input word
  logic [2:0]  kind_r;
  logic [3:0]  tgt_r;
  logic [3:0]  pid_r;
  logic        pnone_r;
  logic [31:0] code_r;

  // staged result
  logic        ok_r, ok_nxt;
  logic [3:0]  sid_r, sid_nxt;
  logic [3:0]  cid_r, cid_nxt;
  logic [1:0]  wake_r, wake_nxt;
  logic [31:0] stat_r, stat_nxt;

  // output register
  logic        out_valid_r;
  logic        out_ok_r;
  logic [3:0]  out_sid_r, out_cid_r;
  logic [1:0]  out_wake_r;
  logic [31:0] out_stat_r;

  // status ram
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  logic [IW-1:0]         tgt_idx, step_idx, scan_p, alloc_idx;
  logic                  tgt_ok;
  pts_pkg::scan_t        scan;
  logic [SLOT_COUNT-1:0] orphan;

  assign tgt_idx  = IW'(tgt_r);
  assign tgt_ok   = SW'(tgt_r) < SW'(SLOT_COUNT);
  assign step_idx = (cur_r == IW'(SLOT_COUNT - 1)) ? '0 : cur_r + 1'b1;
  assign scan_p   = (state_r == S_TICK) ? step_idx : tgt_idx;
  assign alloc_idx = scan.free_found ? scan.free_idx[IW-1:0] : scan.zomb_idx[IW-1:0];

  pts_scan #(.SLOT_COUNT(SLOT_COUNT)) u_scan (
    .st     (st_r),
    .par    (par_r),
    .p      (scan_p),
    .res    (scan),
    .orphan (orphan)
  );

  pts_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_status_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_success     = out_ok_r;
  assign out_slot_id     = out_sid_r;
  assign out_child_id    = out_cid_r;
  assign out_wake_code   = out_wake_r;
  assign out_exit_status = out_stat_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    current_nxt   = current_r;
    from_tick_nxt = from_tick_r;
    st_nxt        = st_r;
    par_nxt       = par_r;
    ok_nxt        = ok_r;
    sid_nxt       = sid_r;
    cid_nxt       = cid_r;
    wake_nxt      = wake_r;
    stat_nxt      = stat_r;
    ram_we        = 1'b0;
    ram_waddr     = tgt_idx;
    ram_wdata     = code_r;
    ram_raddr     = scan.child_idx[IW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ok_nxt    = 1'b0;
          sid_nxt   = '0;
          cid_nxt   = '0;
          wake_nxt  = pts_pkg::WAKE_PLAIN;
          stat_nxt  = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt     = S_FIN;
        from_tick_nxt = 1'b0;
        case (kind_r)
          pts_pkg::KIND_ALLOC: begin
            if (scan.free_found || scan.zomb_found) begin
              st_nxt[alloc_idx]  = pts_pkg::ST_RUN;
              par_nxt[alloc_idx] = pnone_r ? pts_pkg::NO_SLOT : SW'(pid_r);
              ok_nxt  = 1'b1;
              sid_nxt = 4'(alloc_idx);
            end
          end
          pts_pkg::KIND_WAIT: begin
            if (tgt_ok) begin
              case (scan.reap_code)
                pts_pkg::REAP_DONE: begin
                  st_nxt[scan.child_idx[IW-1:0]] = pts_pkg::ST_FREE;
                  st_nxt[tgt_idx] = pts_pkg::ST_RUN;
                  ok_nxt    = 1'b1;
                  cid_nxt   = 4'(scan.child_idx);
                  state_nxt = S_RDST;
                end
                pts_pkg::REAP_NONE:    st_nxt[tgt_idx] = pts_pkg::ST_RUN;
                default:               st_nxt[tgt_idx] = pts_pkg::ST_WAIT;
              endcase
            end
          end
          pts_pkg::KIND_RUN: begin
            if (tgt_ok && st_r[tgt_idx] == pts_pkg::ST_RUN) begin
              current_nxt = SW'(tgt_r);
              ok_nxt  = 1'b1;
              sid_nxt = tgt_r;
            end
          end
          pts_pkg::KIND_EXIT: begin
            if (tgt_ok && (st_r[tgt_idx] == pts_pkg::ST_RUN ||
                           st_r[tgt_idx] == pts_pkg::ST_WAIT)) begin
              st_nxt[tgt_idx] = pts_pkg::ST_ZOMBIE;
              ram_we  = 1'b1;
              ok_nxt  = 1'b1;
              sid_nxt = tgt_r;
            end
          end
          pts_pkg::KIND_TICK: begin
            if (current_r < SW'(SLOT_COUNT)) begin
              cur_nxt   = current_r[IW-1:0];
              cnt_nxt   = '0;
              state_nxt = S_TICK;
            end
          end
          default: ;
        endcase
      end
      S_TICK: begin
        // one slot per cycle, round robin from the current slot
        cur_nxt = step_idx;
        case (st_r[step_idx])
          pts_pkg::ST_ZOMBIE: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (orphan[i]) begin
                par_nxt[i] = pts_pkg::NO_SLOT;
              end
            end
            if (par_r[step_idx] == pts_pkg::NO_SLOT || par_r[step_idx] == SW'(step_idx)) begin
              st_nxt[step_idx] = pts_pkg::ST_FREE;
            end
          end
          pts_pkg::ST_WAIT: begin
            case (scan.reap_code)
              pts_pkg::REAP_DONE: begin
                st_nxt[scan.child_idx[IW-1:0]] = pts_pkg::ST_FREE;
                st_nxt[step_idx] = pts_pkg::ST_RUN;
                ok_nxt   = 1'b1;
                wake_nxt = pts_pkg::WAKE_REAP;
                cid_nxt  = 4'(scan.child_idx);
              end
              pts_pkg::REAP_NONE: begin
                st_nxt[step_idx] = pts_pkg::ST_RUN;
                ok_nxt   = 1'b1;
                wake_nxt = pts_pkg::WAKE_EMPTY;
              end
              default: ;
            endcase
          end
          pts_pkg::ST_RUN: ok_nxt = 1'b1;
          default: ;
        endcase
        if (ok_nxt) begin
          current_nxt = SW'(step_idx);
          sid_nxt     = 4'(step_idx);
          if (wake_nxt == pts_pkg::WAKE_REAP) begin
            from_tick_nxt = 1'b1;
            state_nxt     = S_RDST;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (cnt_r == CW'(2 * SLOT_COUNT - 1)) begin
          current_nxt = SW'(step_idx);
          state_nxt   = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RDST: begin
        // child status arrives, a waking waiter keeps it as its own
        stat_nxt  = ram_rdata;
        ram_we    = from_tick_r;
        ram_waddr = cur_r;
        ram_wdata = ram_rdata;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      current_r   <= pts_pkg::NO_SLOT;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        st_r[i] <= pts_pkg::ST_FREE;
      end
    end else begin
      state_r   <= state_nxt;
      current_r <= current_nxt;
      st_r      <= st_nxt;
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    par_r       <= par_nxt;
    cnt_r       <= cnt_nxt;
    cur_r       <= cur_nxt;
    from_tick_r <= from_tick_nxt;
    ok_r        <= ok_nxt;
    sid_r       <= sid_nxt;
    cid_r       <= cid_nxt;
    wake_r      <= wake_nxt;
    stat_r      <= stat_nxt;
    if (in_valid && in_ready) begin
      kind_r  <= in_kind;
      tgt_r   <= in_target_id;
      pid_r   <= in_parent_id;
      pnone_r <= in_parent_none;
      code_r  <= in_exit_code;
    end
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_ok_r   <= ok_r;
      out_sid_r  <= sid_r;
      out_cid_r  <= cid_r;
      out_wake_r <= wake_r;
      out_stat_r <= stat_r;
    end
  end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  localparam int NSLOT = pts_pkg::SLOT_COUNT_DEF;

  typedef struct packed {
    logic        success;
    logic [3:0]  slot_id;
    logic [3:0]  child_id;
    logic [1:0]  wake_code;
    logic [31:0] exit_status;
  } sched_res_t;

  // keeps its own copy of the process table and the queue of outcomes to come
  class sched_scoreboard;
    logic [1:0]  slot_st [NSLOT];
    logic [4:0]  parent  [NSLOT];
    logic [31:0] status  [NSLOT];
    logic [4:0]  running;
    sched_res_t  outcomes [$];
    int          mismatches;

    function new();
      foreach (slot_st[i]) begin
        slot_st[i] = pts_pkg::ST_FREE;
        parent[i]  = '0;
        status[i]  = '0;
      end
      running    = pts_pkg::NO_SLOT;
      mismatches = 0;
    endfunction

    // scan caller p for children, freeing the first zombie child
    function logic [1:0] collect_child(int p, output logic [3:0] child,
                                       output logic [31:0] stat);
      bit has_child;
      has_child = 0;
      child     = '0;
      stat      = '0;
      for (int i = 0; i < NSLOT; i++) begin
        if (parent[i] != p) continue;
        if (slot_st[i] == pts_pkg::ST_RUN || slot_st[i] == pts_pkg::ST_ZOMBIE)
          has_child = 1;
        if (slot_st[i] == pts_pkg::ST_ZOMBIE) begin
          child      = 4'(i);
          stat       = status[i];
          slot_st[i] = pts_pkg::ST_FREE;
          slot_st[p] = pts_pkg::ST_RUN;
          return pts_pkg::REAP_DONE;
        end
      end
      if (!has_child) begin
        slot_st[p] = pts_pkg::ST_RUN;
        return pts_pkg::REAP_NONE;
      end
      slot_st[p] = pts_pkg::ST_WAIT;
      return pts_pkg::REAP_PENDING;
    endfunction

    function void note_word(logic [2:0] kind, logic [3:0] tgt, logic [3:0] par,
                            logic pnone, logic [31:0] code);
      sched_res_t r;
      int         i;
      int         cur;
      logic [1:0] rc;
      r = '0;
      case (kind)
        pts_pkg::KIND_ALLOC: begin
          for (i = 0; i < NSLOT && slot_st[i] != pts_pkg::ST_FREE; i++) ;
          if (i == NSLOT)
            for (i = 0; i < NSLOT && slot_st[i] != pts_pkg::ST_ZOMBIE; i++) ;
          if (i < NSLOT) begin
            slot_st[i] = pts_pkg::ST_RUN;
            parent[i]  = pnone ? pts_pkg::NO_SLOT : {1'b0, par};
            r.success  = 1;
            r.slot_id  = 4'(i);
          end
        end
        pts_pkg::KIND_WAIT:
          if (collect_child(tgt, r.child_id, r.exit_status) == pts_pkg::REAP_DONE)
            r.success = 1;
        pts_pkg::KIND_RUN:
          if (slot_st[tgt] == pts_pkg::ST_RUN) begin
            running   = {1'b0, tgt};
            r.success = 1;
            r.slot_id = tgt;
          end
        pts_pkg::KIND_EXIT:
          if (slot_st[tgt] == pts_pkg::ST_RUN || slot_st[tgt] == pts_pkg::ST_WAIT) begin
            slot_st[tgt] = pts_pkg::ST_ZOMBIE;
            status[tgt]  = code;
            r.success    = 1;
            r.slot_id    = tgt;
          end
        pts_pkg::KIND_TICK:
          if (running < NSLOT) begin
            cur = running;
            for (int n = 0; n < 2 * NSLOT && !r.success; n++) begin
              cur = (cur + 1) % NSLOT;
              if (slot_st[cur] == pts_pkg::ST_ZOMBIE) begin
                for (int k = 0; k < NSLOT; k++)
                  if (slot_st[k] != pts_pkg::ST_FREE && parent[k] == cur)
                    parent[k] = pts_pkg::NO_SLOT;
                if (parent[cur] == pts_pkg::NO_SLOT) slot_st[cur] = pts_pkg::ST_FREE;
              end
              if (slot_st[cur] == pts_pkg::ST_WAIT) begin
                rc = collect_child(cur, r.child_id, r.exit_status);
                if (rc == pts_pkg::REAP_DONE) begin
                  status[cur] = r.exit_status;
                  r.success   = 1;
                  r.wake_code = pts_pkg::WAKE_REAP;
                end else if (rc == pts_pkg::REAP_NONE) begin
                  r.success   = 1;
                  r.wake_code = pts_pkg::WAKE_EMPTY;
                end
              end
              if (!r.success && slot_st[cur] == pts_pkg::ST_RUN) r.success = 1;
            end
            running = 5'(cur);
            if (r.success) r.slot_id = 4'(cur);
          end
        default: ;
      endcase
      outcomes.push_back(r);
    endfunction

    function void check_word(sched_res_t got);
      sched_res_t exp;
      if (outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
        return;
      end
      exp = outcomes.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p, got %p", exp, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  in_kind = '0;
  logic [3:0]  in_target_id = '0;
  logic [3:0]  in_parent_id = '0;
  logic        in_parent_none = 0;
  logic [31:0] in_exit_code = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        out_success;
  logic [3:0]  out_slot_id;
  logic [3:0]  out_child_id;
  logic [1:0]  out_wake_code;
  logic [31:0] out_exit_status;

  bit              calm = 0;   // no idling on either side while set
  sched_scoreboard sb = new();

  always #1 clk = ~clk;

  process_table_scheduler u_dut (.*);

  // receiver stalls at random
  always @(negedge clk)
    out_ready <= calm || ($urandom_range(99) >= 8);

  // both handshakes sampled on the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_word(in_kind, in_target_id, in_parent_id, in_parent_none, in_exit_code);
    if (rst_n && out_valid && out_ready)
      sb.check_word({out_success, out_slot_id, out_child_id, out_wake_code,
                     out_exit_status});
  end

  // present one word, idling first at random, and hold it until taken
  task automatic send_word(logic [2:0] kind, logic [3:0] tgt, logic [3:0] par,
                           logic pnone, logic [31:0] code);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_kind        = kind;
    in_target_id   = tgt;
    in_parent_id   = par;
    in_parent_none = pnone;
    in_exit_code   = code;
    in_valid       = 1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.outcomes.size() != 0) @(posedge clk);
  endtask

  initial begin
    int kind;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // fill the whole table first so every parent entry is written
    send_word(pts_pkg::KIND_ALLOC, 0, 0, 1, 0);
    for (int i = 1; i < NSLOT; i++)
      send_word(pts_pkg::KIND_ALLOC, 0, (i == 15) ? 4'd15 : 4'(i - 1), 0, 0);
    send_word(pts_pkg::KIND_ALLOC, 0, 3, 0, 0);               // table full
    send_word(pts_pkg::KIND_RUN, 0, 0, 0, 0);
    send_word(pts_pkg::KIND_WAIT, 5, 0, 0, 0);                // child still running
    send_word(pts_pkg::KIND_EXIT, 6, 0, 0, 32'hFFFF_FFFF);
    send_word(pts_pkg::KIND_TICK, 0, 0, 0, 0);                // plain switch
    send_word(pts_pkg::KIND_RUN, 4, 0, 0, 0);
    send_word(pts_pkg::KIND_TICK, 0, 0, 0, 0);                // waiter reaps child
    send_word(pts_pkg::KIND_WAIT, 14, 0, 0, 0);               // no child at all
    send_word(pts_pkg::KIND_EXIT, 0, 0, 0, 32'h0);
    send_word(pts_pkg::KIND_EXIT, 0, 0, 0, 32'h5A5A_A5A5);    // already a zombie
    send_word(pts_pkg::KIND_WAIT, 15, 0, 0, 0);
    send_word(3'd5, 2, 1, 1, 32'h1234_5678);                  // unknown kinds
    send_word(3'd7, 15, 15, 0, 32'hFFFF_FFFF);
    send_word(pts_pkg::KIND_ALLOC, 0, 15, 0, 0);              // reuses freed slot
    send_word(pts_pkg::KIND_RUN, 7, 0, 0, 0);
    send_word(pts_pkg::KIND_TICK, 0, 0, 0, 0);                // plain switch
    send_word(pts_pkg::KIND_WAIT, 1, 0, 0, 0);

    // sender holds off until the pipe is empty
    drain();

    for (int n = 0; n < 1950; n++) begin
      calm = (n >= 700 && n < 1100);
      case ($urandom_range(99)) inside
        [0:17]:  kind = pts_pkg::KIND_ALLOC;
        [18:35]: kind = pts_pkg::KIND_WAIT;
        [36:51]: kind = pts_pkg::KIND_RUN;
        [52:75]: kind = pts_pkg::KIND_TICK;
        [76:96]: kind = pts_pkg::KIND_EXIT;
        default: kind = $urandom_range(7, 5);
      endcase
      send_word(3'(kind), 4'($urandom_range(15)), 4'($urandom_range(15)),
                $urandom_range(7) == 0, $urandom);
    end
    calm = 0;
    drain();
    repeat (80) @(posedge clk);

    if (sb.mismatches == 0 && sb.outcomes.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end
endmodule

// ===== files.f =====
design/pts_pkg.sv
design/pts_ram.sv
design/pts_scan.sv
design/process_table_scheduler.sv
test/tb_top.sv
